### hw/rtl/pldc_pkg.sv
// ----------------------------------------------------------------------------
// pldc_pkg: shared types and constants of the piecewise-linear DAC correction
// Calibration table, per-segment slope data and widths used by the front end,
// the queue and the conversion back end.
// ----------------------------------------------------------------------------
package pldc_pkg;

  // millivolt quantities (input voltage, supply, corrected voltage)
  localparam int unsigned MV_W         = 13;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned DAC_BITS_DEF = 12;

  localparam int unsigned TABLE_POINTS = 13;
  localparam int unsigned SEGS         = TABLE_POINTS - 1;
  localparam int unsigned SEG_W        = $clog2(SEGS);

  // widths of the interpolation datapath, set by the table contents
  localparam int unsigned OFF_W       = 7;   // offset inside a segment, below widest dx
  localparam int unsigned DY_W        = 10;  // rise of a segment
  localparam int unsigned PROD_W      = 17;  // offset * rise
  localparam int unsigned QUO_W       = 10;  // interpolated rise
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;

  localparam logic [MV_W-1:0] SUPPLY_RESET = 13'd3300;

  typedef logic [MV_W-1:0] mv_t;

  localparam mv_t CAL_X [TABLE_POINTS] = '{
    13'd0,   13'd31,  13'd100, 13'd141, 13'd178, 13'd224, 13'd251,
    13'd281, 13'd316, 13'd354, 13'd398, 13'd446, 13'd562
  };

  localparam mv_t CAL_Y [TABLE_POINTS] = '{
    13'd0,    13'd200,  13'd540,  13'd780,  13'd980,  13'd1220, 13'd1360,
    13'd1500, 13'd1720, 13'd1910, 13'd2080, 13'd2300, 13'd2910
  };

  localparam logic [OFF_W-1:0] SEG_DX [SEGS] = '{
    OFF_W'(CAL_X[1]  - CAL_X[0]),  OFF_W'(CAL_X[2]  - CAL_X[1]),
    OFF_W'(CAL_X[3]  - CAL_X[2]),  OFF_W'(CAL_X[4]  - CAL_X[3]),
    OFF_W'(CAL_X[5]  - CAL_X[4]),  OFF_W'(CAL_X[6]  - CAL_X[5]),
    OFF_W'(CAL_X[7]  - CAL_X[6]),  OFF_W'(CAL_X[8]  - CAL_X[7]),
    OFF_W'(CAL_X[9]  - CAL_X[8]),  OFF_W'(CAL_X[10] - CAL_X[9]),
    OFF_W'(CAL_X[11] - CAL_X[10]), OFF_W'(CAL_X[12] - CAL_X[11])
  };

  localparam logic [DY_W-1:0] SEG_DY [SEGS] = '{
    DY_W'(CAL_Y[1]  - CAL_Y[0]),  DY_W'(CAL_Y[2]  - CAL_Y[1]),
    DY_W'(CAL_Y[3]  - CAL_Y[2]),  DY_W'(CAL_Y[4]  - CAL_Y[3]),
    DY_W'(CAL_Y[5]  - CAL_Y[4]),  DY_W'(CAL_Y[6]  - CAL_Y[5]),
    DY_W'(CAL_Y[7]  - CAL_Y[6]),  DY_W'(CAL_Y[8]  - CAL_Y[7]),
    DY_W'(CAL_Y[9]  - CAL_Y[8]),  DY_W'(CAL_Y[10] - CAL_Y[9]),
    DY_W'(CAL_Y[11] - CAL_Y[10]), DY_W'(CAL_Y[12] - CAL_Y[11])
  };

  // floor(2^RECIP_SHIFT / dx): quotient estimate is exact or one low
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
    RECIP_W'(RECIP_ONE / (CAL_X[1]  - CAL_X[0])),
    RECIP_W'(RECIP_ONE / (CAL_X[2]  - CAL_X[1])),
    RECIP_W'(RECIP_ONE / (CAL_X[3]  - CAL_X[2])),
    RECIP_W'(RECIP_ONE / (CAL_X[4]  - CAL_X[3])),
    RECIP_W'(RECIP_ONE / (CAL_X[5]  - CAL_X[4])),
    RECIP_W'(RECIP_ONE / (CAL_X[6]  - CAL_X[5])),
    RECIP_W'(RECIP_ONE / (CAL_X[7]  - CAL_X[6])),
    RECIP_W'(RECIP_ONE / (CAL_X[8]  - CAL_X[7])),
    RECIP_W'(RECIP_ONE / (CAL_X[9]  - CAL_X[8])),
    RECIP_W'(RECIP_ONE / (CAL_X[10] - CAL_X[9])),
    RECIP_W'(RECIP_ONE / (CAL_X[11] - CAL_X[10])),
    RECIP_W'(RECIP_ONE / (CAL_X[12] - CAL_X[11]))
  };

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one corrected request waiting for conversion
  typedef struct packed {
    mv_t  corrected;
    logic hit;
  } qent_t;

endpackage

### hw/rtl/pldc_front.sv
// ----------------------------------------------------------------------------
// pldc_front: segment search and linear interpolation
// Accepts requests, finds the calibration segment and interpolates the
// corrected voltage in a four-stage pipeline that stalls only on a full queue.
// ----------------------------------------------------------------------------
module pldc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pldc_pkg::mv_t        supply,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pldc_pkg::mv_t        req_voltage,
  output logic                 push,
  output pldc_pkg::qent_t      push_data,
  input  logic                 q_full
);
  import pldc_pkg::*;

  logic [3:0]             vld_r;
  logic                   adv;

  logic [SEG_W-1:0]       seg_c;
  logic                   hit_c;
  logic [OFF_W-1:0]       off_c;

  logic [SEG_W-1:0]       s1_seg_r, s2_seg_r, s3_seg_r, s4_seg_r;
  logic                   s1_hit_r, s2_hit_r, s3_hit_r, s4_hit_r;
  logic [OFF_W-1:0]       s1_off_r;
  logic [PROD_W-1:0]      s2_prod_r, s3_prod_r, s4_prod_r;
  logic [QUO_W-1:0]       s3_quo_r, s4_quo_r;
  logic [PROD_W-1:0]      s4_qdx_r;

  logic [PROD_W+RECIP_W-1:0] est_full;
  logic [PROD_W-1:0]         rem_c;
  logic                      inc_c;
  mv_t                       interp_c;

  // hold every stage while the last one cannot hand over
  assign adv       = !(vld_r[3] && q_full);
  assign req_ready = adv;
  assign push      = vld_r[3] && !q_full;

  always_comb begin
    seg_c = '0;
    for (int i = 1; i < SEGS; i++) begin
      if (req_voltage >= CAL_X[i]) begin
        seg_c = SEG_W'(i);
      end
    end
    hit_c = req_voltage < CAL_X[TABLE_POINTS-1];
    off_c = OFF_W'(req_voltage - CAL_X[seg_c]);
  end

  assign est_full = s2_prod_r * SEG_RECIP[s2_seg_r];

  always_comb begin
    rem_c    = s4_prod_r - s4_qdx_r;
    inc_c    = rem_c >= PROD_W'(SEG_DX[s4_seg_r]);
    interp_c = CAL_Y[s4_seg_r] + MV_W'(s4_quo_r) + MV_W'(inc_c);
    push_data.corrected = s4_hit_r ? interp_c : supply;
    push_data.hit       = s4_hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_seg_r  <= seg_c;
      s1_hit_r  <= hit_c;
      s1_off_r  <= off_c;

      s2_seg_r  <= s1_seg_r;
      s2_hit_r  <= s1_hit_r;
      s2_prod_r <= PROD_W'(s1_off_r) * PROD_W'(SEG_DY[s1_seg_r]);

      s3_seg_r  <= s2_seg_r;
      s3_hit_r  <= s2_hit_r;
      s3_prod_r <= s2_prod_r;
      s3_quo_r  <= QUO_W'(est_full >> RECIP_SHIFT);

      s4_seg_r  <= s3_seg_r;
      s4_hit_r  <= s3_hit_r;
      s4_prod_r <= s3_prod_r;
      s4_quo_r  <= s3_quo_r;
      s4_qdx_r  <= PROD_W'(s3_quo_r) * PROD_W'(SEG_DX[s3_seg_r]);
    end
  end

endmodule

### hw/rtl/pldc_queue.sv
// ----------------------------------------------------------------------------
// pldc_queue: short queue between interpolation and conversion
// Small register queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module pldc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pldc_pkg::qent_t   push_data,
  output logic              full,
  input  logic              pop,
  output pldc_pkg::qent_t   pop_data,
  output logic              empty
);
  import pldc_pkg::*;

  qent_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

### hw/rtl/pldc_back.sv
// ----------------------------------------------------------------------------
// pldc_back: voltage to DAC code conversion
// Pipelined restoring divider, one quotient bit per stage, computing
// floor(corrected * (2^DAC_BITS-1) / supply) with saturation at full scale.
// ----------------------------------------------------------------------------
module pldc_back #(
  parameter int unsigned DAC_BITS = pldc_pkg::DAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pldc_pkg::mv_t        supply,
  input  logic                 q_empty,
  output logic                 pop,
  input  pldc_pkg::qent_t      pop_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [DAC_BITS-1:0]  res_code,
  output logic                 res_hit
);
  import pldc_pkg::*;

  localparam int unsigned NUM_W = MV_W + DAC_BITS;

  logic [DAC_BITS:0]     vld_r;
  logic                  adv;
  mv_t                   rem_r [DAC_BITS+1];
  logic [DAC_BITS-1:0]   nlo_r [DAC_BITS+1];
  logic [DAC_BITS-1:0]   quo_r [DAC_BITS+1];
  logic [DAC_BITS:0]     sat_r;
  logic [DAC_BITS:0]     hit_r;
  logic [NUM_W-1:0]      num_c;

  assign adv = !vld_r[DAC_BITS] || res_ready;
  assign pop = adv && !q_empty;

  // corrected * (2^DAC_BITS - 1) as shift and subtract
  assign num_c = {pop_data.corrected, DAC_BITS'(0)} - NUM_W'(pop_data.corrected);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DAC_BITS-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num_c[NUM_W-1:DAC_BITS];
      nlo_r[0] <= num_c[DAC_BITS-1:0];
      quo_r[0] <= '0;
      sat_r[0] <= pop_data.corrected >= supply;
      hit_r[0] <= pop_data.hit;
    end
  end

  for (genvar k = 1; k <= DAC_BITS; k++) begin : g_div
    logic [MV_W:0] trial;
    logic          ge;

    assign trial = {rem_r[k-1], nlo_r[k-1][DAC_BITS-1]};
    assign ge    = trial >= {1'b0, supply};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? MV_W'(trial - {1'b0, supply}) : trial[MV_W-1:0];
        nlo_r[k] <= {nlo_r[k-1][DAC_BITS-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][DAC_BITS-2:0], ge};
        sat_r[k] <= sat_r[k-1];
        hit_r[k] <= hit_r[k-1];
      end
    end
  end

  assign res_valid = vld_r[DAC_BITS];
  assign res_code  = sat_r[DAC_BITS] ? '1 : quo_r[DAC_BITS];
  assign res_hit   = hit_r[DAC_BITS];

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |-> !pop)
    else $error("request taken from queue while output stalled");
  a_miss_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_hit) |-> (res_code == '1))
    else $error("out-of-table request not at full scale");

endmodule

### hw/rtl/piecewise_linear_dac_correction.sv
// ----------------------------------------------------------------------------
// piecewise_linear_dac_correction: calibrated voltage to DAC code
// Top level: supply register, interpolation front end, queue, divider back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per handshake, in_tdata[12:0] = voltage in mV.
//   out_*  : one result per request, in order. out_tdata holds the DAC code,
//            out_tuser is set when the voltage fell inside the calibration table.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into the supply register (mV), used
//            for the out-of-table value and as the conversion divisor. Write
//            only while no request is in flight.
// Path from accept to out_tvalid: four interpolation stages, one queue stage,
//   one divider load stage and one restoring-divider stage per code bit.
// Throughput: one request per cycle without output stalls; divider fully pipelined.
// Reset: pipelines and queue empty, supply register back to 3300 mV.
// Stall: a stalled output freezes the divider pipeline; the queue absorbs
//   up to four requests before the front end drops in_tready.
// ----------------------------------------------------------------------------
module piecewise_linear_dac_correction #(
  parameter int unsigned DAC_BITS = pldc_pkg::DAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pldc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [12:0] voltage_mv
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((DAC_BITS+7)/8)*8-1:0]       out_tdata,  // [DAC_BITS-1:0] dac_code
  output logic                                out_tuser,  // [0] in_table
  input  logic                                cfg_wr_en,
  input  logic [pldc_pkg::MV_W-1:0]           cfg_wr_data // [12:0] supply_millivolts
);
  import pldc_pkg::*;

  localparam int unsigned OUT_TDATA_W = ((DAC_BITS + 7) / 8) * 8;

  mv_t                  supply_r;
  logic                 push, q_full, q_empty, pop;
  qent_t                push_data, pop_data;
  logic [DAC_BITS-1:0]  res_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
    end else if (cfg_wr_en) begin
      supply_r <= cfg_wr_data;
    end
  end

  pldc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .supply      (supply_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_voltage (in_tdata[MV_W-1:0]),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  pldc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  pldc_back #(
    .DAC_BITS (DAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .supply    (supply_r),
    .q_empty   (q_empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_code  (res_code),
    .res_hit   (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(res_code);

endmodule
